/* hw/rtl/manchester_hdlc_frame_transmitter_macros.svh */
// assertion macros used by the checker file of the frame transmitter
`ifndef MANCHESTER_HDLC_FRAME_TRANSMITTER_MACROS_SVH
`define MANCHESTER_HDLC_FRAME_TRANSMITTER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define MHFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame transmitter check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define MHFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame transmitter check failed");

`endif

/* hw/rtl/mhft_pkg.sv */
// shared constants of the manchester hdlc frame transmitter
`default_nettype none

package mhft_pkg;

  // cell kind codes carried on out_tuser[2:0]
  localparam logic [2:0] KIND_SYNC    = 3'd0;
  localparam logic [2:0] KIND_FLAG    = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_STUFF   = 3'd3;
  localparam logic [2:0] KIND_CRC     = 3'd4;

  // framing and crc constants
  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_RESET  = 16'hFFFF;
  localparam logic [2:0]  RUN_LIMIT  = 3'd5;
  localparam int          SYNC_CELLS = 16;

endpackage

`default_nettype wire

/* hw/rtl/manchester_hdlc_frame_transmitter.sv */
// Manchester HDLC frame transmitter: takes payload bytes and emits one bit cell per output beat.
// Each input beat is one payload byte (in_tdata), with in_tlast marking the final byte of a
// frame. The block then sends one Manchester bit cell per output beat, at most one per clock:
// a middle byte gives 8 to 10 cells (payload bits plus stuffed zeros), the first byte of a
// frame adds 16 sync cells and the opening flag (24 cells), and the last byte adds the stuffed
// CRC-16 (16 to 20 cells) and the closing flag (8 cells), so one beat gives 8 to 60 cells. A new
// byte is not taken while one is in work: in_tready is low from the accepting edge until its
// last cell has been loaded into the output register. A single cell serialiser emits the cells
// and also steps the CRC one bit per payload cell.
// The CRC starting value is taken from the configuration register at each frame start.
`default_nettype none

module manchester_hdlc_frame_transmitter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // frame_end
  // bit cell stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] first_level, [1] second_level, [7:2] zero
  output logic [3:0]       out_tuser,  // [2:0] cell_kind, [3] frame_done
  output logic             out_tlast,  // run_last
  // crc initial value register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // crc_initial_value
);
  import mhft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SYNC, S_OFLAG, S_PAY, S_CRCH, S_CRCL, S_CFLAG
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] crc_init_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  ones_r, ones_nxt;
  logic        stuff_r, stuff_nxt;
  logic        in_frame_r, in_frame_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_bit_r, out_bit_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;

  logic        step;
  logic        cell_bit;
  logic [2:0]  ones_inc;
  logic        crc_fb;
  logic        fin;

  // nothing is taken while reset is held
  assign cfg_ready = rst_n;
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign step      = (state_r != S_IDLE) && (!out_valid_r || out_tready);

  // ports from the output register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_bit_r, ~out_bit_r};
  assign out_tuser  = {out_done_r, out_kind_r};
  assign out_tlast  = out_last_r;

  // cell sequencer with the serial crc step
  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    ones_nxt      = ones_r;
    stuff_nxt     = stuff_r;
    in_frame_nxt  = in_frame_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    cell_bit      = sh_r[7];
    ones_inc      = ones_r + 3'd1;
    crc_fb        = crc_r[15] ^ sh_r[7];
    fin           = 1'b0;

    if (state_r == S_IDLE) begin
      if (in_tvalid) begin
        byte_nxt  = in_tdata;
        last_nxt  = in_tlast;
        sh_nxt    = in_tdata;
        cnt_nxt   = 4'd0;
        state_nxt = in_frame_r ? S_PAY : S_SYNC;
      end
    end else if (step) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      out_done_nxt  = 1'b0;
      unique case (state_r)
        S_SYNC: begin
          cell_bit     = cnt_r[0];
          out_kind_nxt = KIND_SYNC;
          cnt_nxt      = cnt_r + 4'd1;
          if (cnt_r == 4'(SYNC_CELLS - 1)) begin
            state_nxt = S_OFLAG;
            sh_nxt    = FLAG_BYTE;
            cnt_nxt   = 4'd0;
          end
        end
        S_OFLAG, S_CFLAG: begin
          out_kind_nxt = KIND_FLAG;
          sh_nxt       = {sh_r[6:0], 1'b0};
          cnt_nxt      = cnt_r + 4'd1;
          if (cnt_r == 4'd7) begin
            cnt_nxt = 4'd0;
            if (state_r == S_OFLAG) begin
              state_nxt    = S_PAY;
              sh_nxt       = byte_r;
              ones_nxt     = 3'd0;
              crc_nxt      = crc_init_r;
              in_frame_nxt = 1'b1;
            end else begin
              state_nxt    = S_IDLE;
              out_last_nxt = 1'b1;
              out_done_nxt = 1'b1;
              in_frame_nxt = 1'b0;
            end
          end
        end
        S_PAY, S_CRCH, S_CRCL: begin
          if (stuff_r) begin
            // inserted zero after five ones
            cell_bit     = 1'b0;
            out_kind_nxt = KIND_STUFF;
            stuff_nxt    = 1'b0;
            fin          = (cnt_r == 4'd8);
          end else begin
            out_kind_nxt = (state_r == S_PAY) ? KIND_PAYLOAD : KIND_CRC;
            sh_nxt       = {sh_r[6:0], 1'b0};
            cnt_nxt      = cnt_r + 4'd1;
            if (sh_r[7]) begin
              if (ones_inc >= RUN_LIMIT) begin
                stuff_nxt = 1'b1;
                ones_nxt  = 3'd0;
              end else begin
                ones_nxt  = ones_inc;
              end
            end else begin
              ones_nxt = 3'd0;
            end
            if (state_r == S_PAY) begin
              crc_nxt = {crc_r[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'd0);
            end
            fin = (cnt_r == 4'd7) && !stuff_nxt;
          end
          // byte finished: move to the next part of the frame
          if (fin) begin
            cnt_nxt = 4'd0;
            case (state_r)
              S_PAY: begin
                if (last_r) begin
                  state_nxt = S_CRCH;
                  sh_nxt    = crc_nxt[15:8];
                end else begin
                  state_nxt    = S_IDLE;
                  out_last_nxt = 1'b1;
                end
              end
              S_CRCH: begin
                state_nxt = S_CRCL;
                sh_nxt    = crc_r[7:0];
              end
              default: begin
                state_nxt = S_CFLAG;
                sh_nxt    = FLAG_BYTE;
                ones_nxt  = 3'd0;
              end
            endcase
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
      out_bit_nxt = cell_bit;
    end
  end

  // state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      crc_init_r  <= CRC_RESET;
      crc_r       <= CRC_RESET;
      sh_r        <= 8'd0;
      cnt_r       <= 4'd0;
      ones_r      <= 3'd0;
      stuff_r     <= 1'b0;
      in_frame_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      sh_r        <= sh_nxt;
      cnt_r       <= cnt_nxt;
      ones_r      <= ones_nxt;
      stuff_r     <= stuff_nxt;
      in_frame_r  <= in_frame_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        crc_init_r <= cfg_data;
      end
    end
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_bit_r  <= out_bit_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/mhft_checker.sv */
// port-level checks of the frame transmitter and their bind
`default_nettype none

`include "manchester_hdlc_frame_transmitter_macros.svh"

module mhft_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic [7:0] out_tdata,
  input wire logic [3:0] out_tuser,
  input wire logic       out_tlast
);
  import mhft_pkg::*;

  // every cell has a mid-cell transition
  `MHFT_ASSERT_NOW(a_manchester, out_tvalid, out_tdata[0] != out_tdata[1])

  // frame end only on the last cell of a byte, inside the closing flag
  `MHFT_ASSERT_NOW(a_done_on_flag, out_tvalid && out_tuser[3], out_tlast && (out_tuser[2:0] == KIND_FLAG))

  // a stuffed cell always carries a zero
  `MHFT_ASSERT_NOW(a_stuff_zero, out_tvalid && (out_tuser[2:0] == KIND_STUFF), out_tdata[1] == 1'b0)

  // a byte takes several cells, so the input closes after each accept
  `MHFT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule

bind manchester_hdlc_frame_transmitter mhft_checker u_mhft_checker (.*);

`default_nettype wire
